// ===== hdl/crpte_pkg.sv =====
// Shared constants, codes and control structs of the point table evaluator.
`timescale 1ns / 1ps
`default_nettype none
package crpte_pkg;

  localparam int MAX_POINTS_DEF = 64;

  // Actions of one input item.
  localparam logic [2:0] ACT_APPEND = 3'd0;
  localparam logic [2:0] ACT_INSERT = 3'd1;
  localparam logic [2:0] ACT_CLEAR  = 3'd2;
  localparam logic [2:0] ACT_READ   = 3'd3;
  localparam logic [2:0] ACT_EVAL   = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_FEW  = 2'd3;

  // Read address selects.
  localparam logic [2:0] RA_BASE  = 3'd0;
  localparam logic [2:0] RA_BASE1 = 3'd1;
  localparam logic [2:0] RA_AUX   = 3'd2;
  localparam logic [2:0] RA_BASE2 = 3'd3;
  localparam logic [2:0] RA_KM1   = 3'd4;
  localparam logic [2:0] RA_SLOT  = 3'd5;

  // Capture targets for read data.
  localparam logic [1:0] CAP_PA = 2'd0;
  localparam logic [1:0] CAP_PB = 2'd1;
  localparam logic [1:0] CAP_D0 = 2'd2;
  localparam logic [1:0] CAP_D1 = 2'd3;

  // Kinds of result payload.
  localparam logic [1:0] KIND_ZERO  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CURVE = 2'd2;

  typedef struct packed {
    logic       latch;
    logic       k_load;
    logic       k_dec;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       cap_en;
    logic [1:0] cap_sel;
    logic       wr_shift;
    logic       wr_new;
    logic       cnt_inc;
    logic       cnt_clr;
    logic       sq_en;
    logic       cu_en;
    logic       wt_en;
    logic       acc_init;
    logic       mul_en;
    logic [1:0] mul_comp;
    logic [1:0] mul_term;
    logic       res_en;
    logic [1:0] res_kind;
    logic [1:0] res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       full;
    logic       pos_bad;
    logic       k_gt_pos;
    logic       rd_bad;
    logic       few;
    logic       two;
    logic       seg_bad;
    logic       out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== hdl/crpte_if.sv =====
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps
`default_nettype none
interface crpte_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic signed [31:0] coord_w;
  logic [6:0]         slot;
  logic [16:0]        factor;

  modport source (output valid, action, coord_x, coord_y, coord_z, coord_w, slot, factor,
                  input ready);
  modport sink (input valid, action, coord_x, coord_y, coord_z, coord_w, slot, factor,
                output ready);
endinterface

interface crpte_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] out_w;
  logic [6:0]         point_count;
  logic [1:0]         status;

  modport source (output valid, out_x, out_y, out_z, out_w, point_count, status,
                  input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, point_count, status,
                output ready);
endinterface
`default_nettype wire

// ===== hdl/crpte_ctrl.sv =====
// Controller state machine that sequences table updates, reads and evaluation.
`timescale 1ns / 1ps
`default_nettype none
module crpte_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire crpte_pkg::dp_stat_t st,
  output crpte_pkg::dp_cmd_t      cmd
);
  import crpte_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_SH_CHK = 4'd2;
  localparam logic [3:0] S_SH_RD  = 4'd3;
  localparam logic [3:0] S_SH_WR  = 4'd4;
  localparam logic [3:0] S_WR_NEW = 4'd5;
  localparam logic [3:0] S_EV_RD  = 4'd6;
  localparam logic [3:0] S_EV_MUL = 4'd7;
  localparam logic [3:0] S_EV_DRN = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic [1:0] fin_stat_r, fin_stat_nxt;
  logic [1:0] fin_kind_r, fin_kind_nxt;
  logic       last;

  // State and step registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      step_r     <= '0;
      fin_stat_r <= ST_OK;
      fin_kind_r <= KIND_ZERO;
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      fin_stat_r <= fin_stat_nxt;
      fin_kind_r <= fin_kind_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    fin_stat_nxt = fin_stat_r;
    fin_kind_nxt = fin_kind_r;
    cmd          = '0;
    in_ready     = 1'b0;
    last         = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        fin_stat_nxt = ST_OK;
        fin_kind_nxt = KIND_ZERO;
        state_nxt    = S_FIN;
        case (st.act)
          ACT_APPEND, ACT_INSERT: begin
            if (st.full) begin
              fin_stat_nxt = ST_FULL;
            end else if (st.pos_bad) begin
              fin_stat_nxt = ST_BAD;
            end else begin
              cmd.k_load = 1'b1;
              state_nxt  = S_SH_CHK;
            end
          end
          ACT_CLEAR: begin
            cmd.cnt_clr = 1'b1;
          end
          ACT_READ: begin
            if (st.rd_bad) begin
              fin_stat_nxt = ST_BAD;
            end else begin
              cmd.rd_en    = 1'b1;
              cmd.rd_sel   = RA_SLOT;
              fin_kind_nxt = KIND_READ;
            end
          end
          ACT_EVAL: begin
            if (st.few) begin
              fin_stat_nxt = ST_FEW;
            end else if (!st.two && st.seg_bad) begin
              fin_stat_nxt = ST_BAD;
            end else begin
              step_nxt  = '0;
              state_nxt = S_EV_RD;
            end
          end
          default: begin
            fin_stat_nxt = ST_OK;
          end
        endcase
      end
      S_SH_CHK: begin
        state_nxt = st.k_gt_pos ? S_SH_RD : S_WR_NEW;
      end
      S_SH_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_KM1;
        state_nxt  = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.k_dec    = 1'b1;
        state_nxt    = S_SH_CHK;
      end
      S_WR_NEW: begin
        cmd.wr_new   = 1'b1;
        cmd.cnt_inc  = 1'b1;
        fin_stat_nxt = ST_OK;
        fin_kind_nxt = KIND_ZERO;
        state_nxt    = S_FIN;
      end
      // Four table reads overlap the weight computation.
      S_EV_RD: begin
        cmd.rd_en   = (step_r < 4'd4);
        cmd.cap_en  = (step_r != 4'd0);
        cmd.cap_sel = 2'(step_r - 4'd1);
        cmd.sq_en   = (step_r == 4'd0);
        cmd.cu_en   = (step_r == 4'd1);
        cmd.wt_en   = (step_r == 4'd2);
        case (step_r[1:0])
          2'd0:    cmd.rd_sel = RA_BASE;
          2'd1:    cmd.rd_sel = RA_BASE1;
          2'd2:    cmd.rd_sel = RA_AUX;
          default: cmd.rd_sel = RA_BASE2;
        endcase
        if (step_r == 4'd4) begin
          cmd.acc_init = 1'b1;
          step_nxt     = '0;
          state_nxt    = S_EV_MUL;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      // One product per cycle through the shared multiplier.
      S_EV_MUL: begin
        cmd.mul_en = 1'b1;
        if (st.two) begin
          cmd.mul_comp = step_r[1:0];
          cmd.mul_term = 2'd0;
          last         = (step_r == 4'd3);
        end else begin
          cmd.mul_comp = step_r[3:2];
          cmd.mul_term = step_r[1:0];
          last         = (step_r == 4'd15);
        end
        if (last) begin
          step_nxt  = '0;
          state_nxt = S_EV_DRN;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      S_EV_DRN: begin
        fin_stat_nxt = ST_OK;
        fin_kind_nxt = KIND_CURVE;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        if (!st.out_busy) begin
          cmd.res_en     = 1'b1;
          cmd.res_kind   = fin_kind_r;
          cmd.res_status = fin_stat_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/crpte_dp.sv =====
// Datapath: point memory, count, tangents, Hermite weights, multiplier and output register.
`timescale 1ns / 1ps
`default_nettype none
module crpte_dp #(
  parameter int MAX_POINTS = crpte_pkg::MAX_POINTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire crpte_pkg::dp_cmd_t cmd,
  output crpte_pkg::dp_stat_t     st,
  input  wire logic [2:0]         in_action,
  input  wire logic [127:0]       in_coords,
  input  wire logic [6:0]         in_slot,
  input  wire logic [16:0]        in_factor,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [127:0]            out_data,
  output logic [6:0]              out_count,
  output logic [1:0]              out_status
);
  import crpte_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int XW = ((CW > 7) ? CW : 7) + 1;
  localparam logic signed [53:0] ONE48  = 54'sh1000000000000;
  localparam logic signed [53:0] HALF17 = 54'sh20000;
  localparam logic signed [67:0] HALF30 = 68'sh40000000;
  localparam logic signed [67:0] HALF15 = 68'sh8000;
  localparam logic signed [67:0] SMAX   = 68'sh7FFFFFFF;
  localparam logic signed [67:0] SMIN   = -68'sh80000000;

  function automatic logic signed [33:0] ext34(input logic signed [31:0] v);
    ext34 = {{2{v[31]}}, v};
  endfunction

  function automatic logic signed [31:0] wround(input logic signed [53:0] v);
    logic signed [53:0] s;
    s = (v + HALF17) >>> 18;
    wround = s[31:0];
  endfunction

  // Item, table and arithmetic registers.
  logic [2:0]          act_r;
  logic [127:0]        crd_r;
  logic [6:0]          slot_r;
  logic [16:0]         t_r;
  logic [CW-1:0]       cnt_r;
  logic [CW-1:0]       k_r;
  logic [127:0]        mem [MAX_POINTS];
  logic [127:0]        rdata_r;
  logic signed [31:0]  pa_r [4];
  logic signed [31:0]  pb_r [4];
  logic signed [33:0]  d0_r [4];
  logic signed [33:0]  d1_r [4];
  logic [33:0]         t2_r;
  logic [50:0]         t3_r;
  logic signed [31:0]  w_r [4];
  logic signed [65:0]  prod_r;
  logic [1:0]          prodc_r;
  logic                prodv_r;
  logic signed [67:0]  acc_r [4];
  logic                out_valid_r;
  logic [127:0]        out_data_r;
  logic [6:0]          out_count_r;
  logic [1:0]          out_status_r;

  logic [XW-1:0] cnt_x, slot_x, pos_x, base_x, k_x, rd_x;
  logic          two;
  logic          d1_ok;
  logic [AW-1:0] wr_addr;
  logic [127:0]  wr_data;
  logic signed [31:0] rd_c [4];
  logic signed [53:0] t3s, t2s, tts;
  logic signed [33:0] op_a;
  logic signed [31:0] op_b;
  logic signed [65:0] mul_full;
  logic signed [67:0] shifted [4];
  logic [127:0]  curve;

  // Index arithmetic and status flags.
  always_comb begin
    cnt_x  = XW'(cnt_r);
    slot_x = XW'(slot_r);
    k_x    = XW'(k_r);
    two    = (cnt_r == CW'(2));
    pos_x  = (act_r == ACT_INSERT) ? slot_x : cnt_x;
    base_x = two ? '0 : slot_x;
    d1_ok  = (base_x + XW'(2)) < cnt_x;
    case (cmd.rd_sel)
      RA_BASE:  rd_x = base_x;
      RA_BASE1: rd_x = base_x + XW'(1);
      RA_AUX:   rd_x = (base_x == '0) ? XW'(2) : base_x - XW'(1);
      RA_BASE2: rd_x = base_x + XW'(2);
      RA_KM1:   rd_x = k_x - XW'(1);
      RA_SLOT:  rd_x = slot_x;
      default:  rd_x = slot_x;
    endcase
    st.act      = act_r;
    st.full     = (cnt_r == CW'(MAX_POINTS));
    st.pos_bad  = pos_x > cnt_x;
    st.k_gt_pos = k_x > pos_x;
    st.rd_bad   = slot_x >= cnt_x;
    st.few      = cnt_r < CW'(2);
    st.two      = two;
    st.seg_bad  = (slot_x + XW'(1)) >= cnt_x;
    st.out_busy = out_valid_r && !out_ready;
    wr_addr     = cmd.wr_shift ? k_r[AW-1:0] : pos_x[AW-1:0];
    wr_data     = cmd.wr_shift ? rdata_r : crd_r;
  end

  // Item latch, count and shift index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r  <= in_action;
      crd_r  <= in_coords;
      slot_r <= in_slot;
      t_r    <= (in_factor > 17'd65536) ? 17'd65536 : in_factor;
    end
    if (cmd.k_load) begin
      k_r <= cnt_r;
    end else if (cmd.k_dec) begin
      k_r <= k_r - CW'(1);
    end
  end

  // Point memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_shift || cmd.wr_new) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_x[AW-1:0]];
    end
  end

  // Capture of points and tangents from read data.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      rd_c[c] = rdata_r[32*c +: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      for (int c = 0; c < 4; c++) begin
        case (cmd.cap_sel)
          CAP_PA: pa_r[c] <= rd_c[c];
          CAP_PB: pb_r[c] <= rd_c[c];
          CAP_D0: begin
            if (base_x == '0) begin
              d0_r[c] <= (ext34(rd_c[c]) - ext34(pa_r[c])) <<< 1;
            end else begin
              d0_r[c] <= ext34(pb_r[c]) - ext34(rd_c[c]);
            end
          end
          default: d1_r[c] <= d1_ok ? ext34(rd_c[c]) - ext34(pa_r[c]) : 34'sd0;
        endcase
      end
    end
  end

  // Powers of t and the four Hermite weights in Q2.30.
  always_comb begin
    t3s = $signed({3'b0, t3_r});
    t2s = $signed({4'b0, t2_r, 16'b0});
    tts = $signed({5'b0, t_r, 32'b0});
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_en) begin
      t2_r <= 34'(t_r) * 34'(t_r);
    end
    if (cmd.cu_en) begin
      t3_r <= 51'(t2_r) * 51'(t_r);
    end
    if (cmd.wt_en) begin
      w_r[0] <= wround(54'sd2 * t3s - 54'sd3 * t2s + ONE48);
      w_r[1] <= wround(54'sd3 * t2s - 54'sd2 * t3s);
      w_r[2] <= wround(t3s - 54'sd2 * t2s + tts);
      w_r[3] <= wround(t3s - t2s);
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    if (two) begin
      op_a = ext34(pb_r[cmd.mul_comp]) - ext34(pa_r[cmd.mul_comp]);
      op_b = $signed({15'b0, t_r});
    end else begin
      case (cmd.mul_term)
        2'd0:    op_a = ext34(pa_r[cmd.mul_comp]) <<< 1;
        2'd1:    op_a = ext34(pb_r[cmd.mul_comp]) <<< 1;
        2'd2:    op_a = d0_r[cmd.mul_comp];
        default: op_a = d1_r[cmd.mul_comp];
      endcase
      op_b = w_r[cmd.mul_term];
    end
    mul_full = op_a * op_b;
  end

  // Product register and per-component accumulators.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prodv_r <= 1'b0;
    end else begin
      prodv_r <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r  <= mul_full;
      prodc_r <= cmd.mul_comp;
    end
    if (cmd.acc_init) begin
      for (int c = 0; c < 4; c++) begin
        acc_r[c] <= two ? ((68'(pa_r[c]) <<< 16) + HALF15) : HALF30;
      end
    end else if (prodv_r) begin
      acc_r[prodc_r] <= acc_r[prodc_r] + 68'(prod_r);
    end
  end

  // Rounding shift and saturation of the curve value.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      shifted[c] = two ? (acc_r[c] >>> 16) : (acc_r[c] >>> 31);
      if (shifted[c] > SMAX) begin
        curve[32*c +: 32] = 32'h7FFFFFFF;
      end else if (shifted[c] < SMIN) begin
        curve[32*c +: 32] = 32'h80000000;
      end else begin
        curve[32*c +: 32] = shifted[c][31:0];
      end
    end
  end

  // Output register: holds a result until its transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_en) begin
      case (cmd.res_kind)
        KIND_READ:  out_data_r <= rdata_r;
        KIND_CURVE: out_data_r <= curve;
        default:    out_data_r <= '0;
      endcase
      out_count_r  <= cnt_x[6:0];
      out_status_r <= cmd.res_status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_count  = out_count_r;
  assign out_status = out_status_r;

endmodule
`default_nettype wire

// ===== hdl/catmull_rom_point_table_eval_top.sv =====
// Top level of the point table evaluator: controller, datapath and channel wiring.
// An insert shifts each later point up one slot, then writes the new one; an evaluate is linear
// for a two-point table and Hermite otherwise, both through the shared multiplier.
// One item at a time; the next is taken after its result is registered in a free output.
// The memory has one read and one write port; a shifted point takes a check, a read and a write.
// Reset (rst_n low, synchronous) empties the table and drops any held result.
`timescale 1ns / 1ps
`default_nettype none
module catmull_rom_point_table_eval_top #(
  parameter int MAX_POINTS = crpte_pkg::MAX_POINTS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  crpte_in_if.sink  in_ch,
  crpte_out_if.source out_ch
);
  import crpte_pkg::*;

  dp_cmd_t      cmd;
  dp_stat_t     st;
  logic         ctl_in_ready;
  logic [127:0] out_data;

  // Controller.
  crpte_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ctl_in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath.
  crpte_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_action  (in_ch.action),
    .in_coords  ({in_ch.coord_w, in_ch.coord_z, in_ch.coord_y, in_ch.coord_x}),
    .in_slot    (in_ch.slot),
    .in_factor  (in_ch.factor),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_data   (out_data),
    .out_count  (out_ch.point_count),
    .out_status (out_ch.status)
  );

  // Channel wiring.
  assign in_ch.ready  = ctl_in_ready;
  assign out_ch.out_x = out_data[31:0];
  assign out_ch.out_y = out_data[63:32];
  assign out_ch.out_z = out_data[95:64];
  assign out_ch.out_w = out_data[127:96];

endmodule
`default_nettype wire
